[rtl/csxt_pkg.sv]
package csxt_pkg;

    // Sizing
    localparam int NUM_FUNCS   = 256;
    localparam int STACK_DEPTH = 64;
    localparam int TIME_BITS   = 32;

    // Port field widths
    localparam int ACT_W = 2;
    localparam int ID_W  = 8;
    localparam int TS_W  = 32;
    localparam int ST_W  = 2;

    // Derived index widths
    localparam int FN_AW  = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
    localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);

    typedef logic [TIME_BITS-1:0] time_t;

    localparam time_t TIME_MAX = {TIME_BITS{1'b1}};

    // Event codes; the unused code behaves as a readout
    typedef enum logic [ACT_W-1:0] {
        ACT_START = 2'd0,
        ACT_END   = 2'd1,
        ACT_READ  = 2'd2
    } action_e;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_e;

    // One call stack frame
    typedef struct packed {
        logic [ID_W-1:0] id;
        time_t           start;
        time_t           child;
    } stk_entry_t;

    // Add two times, clamp at the time maximum
    function automatic time_t sat_add(input time_t a, input time_t b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
    endfunction

endpackage

[rtl/call_stack_exclusive_time_top.sv]
// Channel  | Direction | Ports                                           | Beat
// ---------+-----------+-------------------------------------------------+----------------------
// s_       | in        | s_valid s_ready s_action s_func_id s_timestamp  | one trace event
// m_       | out       | m_valid m_ready m_result_func m_exclusive_total | one result per event
//          |           | m_segment_time m_status                         |
//
// One event per cycle sustained while m_ready is high. A result reaches the output register
// through the middle stage: the accepting edge does the stack update and totals read, the
// middle stage adds the segment into the total, and the output register captures the sum.
// The stack top and next entry sit in registers, deeper frames in a memory with one write
// and one registered read port; totals live in a memory with a valid bit per entry.
// Reset (aresetn low at a clock edge) empties the stack and clears the valid bits at once;
// no clearing pass is needed. A stalled m_ready holds the result register; one more event
// is still taken into the middle stage before s_ready drops.
module call_stack_exclusive_time_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [csxt_pkg::ACT_W-1:0]    s_action,
    input  logic [csxt_pkg::ID_W-1:0]     s_func_id,
    input  logic [csxt_pkg::TS_W-1:0]     s_timestamp,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [csxt_pkg::ID_W-1:0]     m_result_func,
    output logic [csxt_pkg::TS_W-1:0]     m_exclusive_total,
    output logic [csxt_pkg::TS_W-1:0]     m_segment_time,
    output logic [csxt_pkg::ST_W-1:0]     m_status
);
    import csxt_pkg::*;

    // Stack state
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    stk_entry_t       top_reg, top_next;
    stk_entry_t       sec_reg, sec_next;
    stk_entry_t       third_reg;
    stk_entry_t       stk_mem [STACK_DEPTH];
    logic [LVL_W-1:0] wr_idx, rd_idx;
    logic             stk_we;

    // Event decode
    logic               s_fire;
    logic               is_start, is_end, push_ok, pop_ok;
    time_t              a_t, span, seg;
    logic [TIME_BITS:0] diff1;
    logic [ID_W-1:0]    a_func;
    logic [FN_AW-1:0]   a_slot;
    status_e            a_status;
    logic               a_use_tot;

    // Totals store
    time_t              tot_mem [NUM_FUNCS];
    time_t              tot_rd_reg;
    logic [NUM_FUNCS-1:0] tot_vld_reg;

    // Middle stage
    logic             b_valid_reg, b_valid_next;
    logic [ID_W-1:0]  b_func_reg;
    logic [FN_AW-1:0] b_slot_reg;
    time_t            b_seg_reg;
    status_e          b_status_reg;
    logic             b_add_reg, b_use_tot_reg, b_vld_reg, b_fwd_reg;
    time_t            b_fwd_data_reg;
    time_t            b_old, b_new;
    logic             b_adv, b_wr;

    // Output register
    logic             m_valid_reg;
    logic [ID_W-1:0]  m_func_reg;
    logic [TS_W-1:0]  m_total_reg, m_seg_reg;
    status_e          m_status_reg;

    // Handshake
    assign b_adv   = !m_valid_reg || m_ready;
    assign s_ready = !b_valid_reg || b_adv;
    assign s_fire  = s_valid && s_ready;
    assign b_wr    = b_valid_reg && b_adv && b_add_reg;

    // Decode the event against the stack top
    always_comb begin
        is_start = (s_action == ACT_START);
        is_end   = (s_action == ACT_END);
        push_ok  = is_start && (lvl_reg < LVL_W'(STACK_DEPTH));
        pop_ok   = is_end && (lvl_reg != '0);
        a_t      = time_t'(s_timestamp);
        diff1    = (TIME_BITS+1)'(a_t - top_reg.start) + (TIME_BITS+1)'(1);
        if (a_t >= top_reg.start) begin
            span = diff1[TIME_BITS] ? TIME_MAX : diff1[TIME_BITS-1:0];
        end else begin
            span = '0;
        end
        seg = (pop_ok && (span > top_reg.child)) ? (span - top_reg.child) : '0;
        if (is_end) begin
            a_func = pop_ok ? top_reg.id : '0;
        end else begin
            a_func = s_func_id;
        end
        a_slot = FN_AW'(a_func % NUM_FUNCS);
        if (is_start && !push_ok) begin
            a_status = ST_FULL;
        end else if (is_end && !pop_ok) begin
            a_status = ST_EMPTY;
        end else begin
            a_status = ST_OK;
        end
        a_use_tot = !(is_end && !pop_ok);
    end

    // Next stack state: push spills the second entry, pop pulls the third up
    always_comb begin
        lvl_next = lvl_reg;
        top_next = top_reg;
        sec_next = sec_reg;
        if (s_fire && push_ok) begin
            lvl_next       = lvl_reg + LVL_W'(1);
            top_next.id    = s_func_id;
            top_next.start = a_t;
            top_next.child = '0;
            sec_next       = top_reg;
        end else if (s_fire && pop_ok) begin
            lvl_next       = lvl_reg - LVL_W'(1);
            top_next       = sec_reg;
            top_next.child = sat_add(sec_reg.child, span);
            sec_next       = third_reg;
        end
    end

    assign wr_idx = lvl_reg - LVL_W'(2);
    assign rd_idx = lvl_reg - LVL_W'(4);
    assign stk_we = s_fire && push_ok && (lvl_reg >= LVL_W'(2));

    // Hold stack depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_reg <= '0;
        end else begin
            lvl_reg <= lvl_next;
        end
    end

    // Hold top two frames
    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        sec_reg <= sec_next;
    end

    // Deep frames; third frame is the registered read, bypassed on push
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[wr_idx[STK_AW-1:0]] <= sec_reg;
        end
        if (s_fire && push_ok) begin
            third_reg <= sec_reg;
        end else if (s_fire && pop_ok) begin
            third_reg <= stk_mem[rd_idx[STK_AW-1:0]];
        end
    end

    // Totals memory: write from middle stage, registered read on accept
    always_ff @(posedge aclk) begin
        if (b_wr) begin
            tot_mem[b_slot_reg] <= b_new;
        end
        if (s_fire) begin
            tot_rd_reg <= tot_mem[a_slot];
        end
    end

    // Mark totals written since reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tot_vld_reg <= '0;
        end else if (b_wr) begin
            tot_vld_reg[b_slot_reg] <= 1'b1;
        end
    end

    // Advance middle stage
    always_comb begin
        if (s_fire) begin
            b_valid_next = 1'b1;
        end else if (b_adv) begin
            b_valid_next = 1'b0;
        end else begin
            b_valid_next = b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    // Capture event beat; forward a total written at the same edge
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            b_func_reg     <= a_func;
            b_slot_reg     <= a_slot;
            b_seg_reg      <= seg;
            b_status_reg   <= a_status;
            b_add_reg      <= pop_ok;
            b_use_tot_reg  <= a_use_tot;
            b_vld_reg      <= tot_vld_reg[a_slot];
            b_fwd_reg      <= b_wr && (b_slot_reg == a_slot);
            b_fwd_data_reg <= b_new;
        end
    end

    // Add segment time into the total
    always_comb begin
        if (b_fwd_reg) begin
            b_old = b_fwd_data_reg;
        end else if (b_vld_reg) begin
            b_old = tot_rd_reg;
        end else begin
            b_old = '0;
        end
        b_new = b_add_reg ? sat_add(b_old, b_seg_reg) : b_old;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_adv) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg && b_adv) begin
            m_func_reg   <= b_func_reg;
            m_total_reg  <= b_use_tot_reg ? TS_W'(b_new) : '0;
            m_seg_reg    <= TS_W'(b_seg_reg);
            m_status_reg <= b_status_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_result_func     = m_func_reg;
    assign m_exclusive_total = m_total_reg;
    assign m_segment_time    = m_seg_reg;
    assign m_status          = m_status_reg;

    // Checks
    a_lvl_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lvl_reg <= LVL_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_pop_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && is_end && (lvl_reg != '0)) |=> (lvl_reg == $past(lvl_reg) - LVL_W'(1)))
        else $error("pop did not lower stack depth");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_EMPTY)) |->
            ((m_exclusive_total == '0) && (m_segment_time == '0) && (m_result_func == '0)))
        else $error("empty-stack result carries data");

    a_seg_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_segment_time != '0)) |-> (m_status == ST_OK))
        else $error("segment time on a rejected event");

endmodule
